// ----- hw/rtl/gbm_path_payoff_accumulator_defines.svh -----
// Assertion macros shared by the RTL of the path payoff accumulator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GBM_PATH_PAYOFF_ACCUMULATOR_DEFINES_SVH
`define GBM_PATH_PAYOFF_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define GPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/gpa_pkg.sv -----
// Types, codes and constants of the path payoff accumulator.
// No dependencies.
`default_nettype none
package gpa_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T,
        ST_TC,
        ST_Y,
        ST_YC,
        ST_U,
        ST_UC,
        ST_H1,
        ST_H1C,
        ST_H2,
        ST_H2C,
        ST_P,
        ST_PC,
        ST_DONE
    } gpa_state_t;

    // configuration register indexes
    localparam logic [2:0] REG_START_PRICE = 3'd0;
    localparam logic [2:0] REG_STRIKE      = 3'd1;
    localparam logic [2:0] REG_DRIFT       = 3'd2;
    localparam logic [2:0] REG_DIFFUSION   = 3'd3;
    localparam logic [2:0] REG_INCREMENTS  = 3'd4;
    localparam logic [2:0] REG_MODE        = 3'd5;

    // value modes
    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_CALL = 2'd1;

    localparam int unsigned MAX_STEPS = 4096;

    localparam logic signed [32:0] C_LOG2E_Q29 = 33'sd774541002;
    localparam logic signed [32:0] C_LN2_Q30   = 33'sd744261118;
    localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;
    localparam logic signed [37:0] EXP_CLAMP   = 38'sd6442450944;
    localparam logic [47:0]        SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0]        COUNT_MAX   = 24'hFF_FFFF;

    // floor(2^32 / k) for the Horner divisions, k = 2..10
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        logic [31:0] m;
        case (k)
            4'd2:    m = 32'd2147483648;
            4'd3:    m = 32'd1431655765;
            4'd4:    m = 32'd1073741824;
            4'd5:    m = 32'd858993459;
            4'd6:    m = 32'd715827882;
            4'd7:    m = 32'd613566756;
            4'd8:    m = 32'd536870912;
            4'd9:    m = 32'd477218588;
            4'd10:   m = 32'd429496729;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gpa_channels.sv -----
// Valid/ready channel interfaces: samples in, path results out, config writes.
// No dependencies.
`default_nettype none
interface gpa_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_sample;
    logic               clear_totals;
    modport source(output valid, normal_sample, clear_totals, input ready);
    modport sink(input valid, normal_sample, clear_totals, output ready);
endinterface

interface gpa_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] path_value;
    logic [47:0] value_sum;
    logic [23:0] paths_done;
    modport source(output valid, path_value, value_sum, paths_done, input ready);
    modport sink(input valid, path_value, value_sum, paths_done, output ready);
endinterface

interface gpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/gbm_path_payoff_accumulator.sv -----
// Each accepted sample multiplies the price by exp(drift + diffusion*z) in fixed
// point with one shared signed 35x33 multiplier under a small sequencer; the exp
// is a degree-10 Horner series whose divisions by k use reciprocal multiplies. Each
// sample runs through 23 multiplies, each followed by a post-processing state, then
// the finish state; sample ready is low until the sequencer is back in idle. A
// sample that finishes a path waits in the finish state, with ready still low,
// while the previous result is not yet taken. When the configured step count is
// reached the path value, saturating sum and count are posted in an output
// register, and the path restarts from start_price. Config writes are always taken.
`default_nettype none
`include "gbm_path_payoff_accumulator_defines.svh"
module gbm_path_payoff_accumulator
    import gpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gpa_cfg_if.sink    cfg,
    gpa_sample_if.sink sample,
    gpa_result_if.source result
);

    // configuration
    logic [31:0]        start_reg;
    logic [31:0]        strike_reg;
    logic signed [31:0] drift_reg;
    logic [30:0]        diff_reg;
    logic [11:0]        inc_reg;
    logic [1:0]         mode_reg;

    // sequencer and datapath
    gpa_state_t         state_reg, state_next;
    logic signed [15:0] z_reg;
    logic signed [67:0] prod_reg, prod_next;
    logic signed [34:0] t_reg, t_next;
    logic signed [7:0]  n_reg, n_next;
    logic [27:0]        f_reg, f_next;
    logic [29:0]        u_reg, u_next;
    logic [31:0]        s_reg, s_next;
    logic [31:0]        x_reg, x_next;
    logic [3:0]         k_reg, k_next;
    logic [31:0]        price_reg, price_next;
    logic [11:0]        step_reg, step_next;
    logic [47:0]        sum_reg, sum_next;
    logic [23:0]        count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_value_reg, out_value_next;
    logic [47:0]        out_sum_reg, out_sum_next;
    logic [23:0]        out_count_reg, out_count_next;

    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic               accept;
    logic [11:0]        limit;
    logic [11:0]        step_inc;
    logic               finish;
    logic               out_free;

    assign accept    = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.path_value = out_value_reg;
    assign result.value_sum  = out_sum_reg;
    assign result.paths_done = out_count_reg;

    // step limit: zero acts as one, capped below MAX_STEPS
    always_comb
    begin
        if (inc_reg == 12'd0)
            limit = 12'd1;
        else if (32'(inc_reg) > MAX_STEPS - 1)
            limit = 12'(MAX_STEPS - 1);
        else
            limit = inc_reg;
    end

    assign step_inc = step_reg + 12'd1;
    assign finish   = (step_inc >= limit);
    assign out_free = !out_valid_reg || result.ready;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_T:
            begin
                mul_a = 35'(z_reg);
                mul_b = $signed({2'b00, diff_reg});
            end
            ST_Y:
            begin
                mul_a = t_reg;
                mul_b = C_LOG2E_Q29;
            end
            ST_U:
            begin
                mul_a = $signed({7'd0, f_reg});
                mul_b = C_LN2_Q30;
            end
            ST_H1:
            begin
                mul_a = $signed({5'd0, u_reg});
                mul_b = $signed({1'b0, s_reg});
            end
            ST_H2:
            begin
                mul_a = $signed({3'd0, x_reg});
                mul_b = $signed({1'b0, recip_k(k_reg)});
            end
            ST_P:
            begin
                mul_a = $signed({3'd0, s_reg});
                mul_b = $signed({1'b0, price_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_T;
            ST_T:    state_next = ST_TC;
            ST_TC:   state_next = ST_Y;
            ST_Y:    state_next = ST_YC;
            ST_YC:   state_next = ST_U;
            ST_U:    state_next = ST_UC;
            ST_UC:   state_next = ST_H1;
            ST_H1:   state_next = ST_H1C;
            ST_H1C:  state_next = (k_reg == 4'd1) ? ST_P : ST_H2;
            ST_H2:   state_next = ST_H2C;
            ST_H2C:  state_next = ST_H1;
            ST_P:    state_next = ST_PC;
            ST_PC:   state_next = ST_DONE;
            ST_DONE: if (!finish || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath register updates
    always_comb
    begin
        logic signed [67:0] shr;
        logic signed [37:0] tsum;
        logic signed [35:0] y;
        logic [31:0]        q0;
        logic [35:0]        qk;
        logic [35:0]        rem;
        logic [31:0]        q;
        logic signed [8:0]  rsh;
        logic [5:0]         lsh;
        logic [62:0]        p;
        logic [62:0]        pr;
        logic [31:0]        v;
        logic [48:0]        sum_w;

        t_next         = t_reg;
        n_next         = n_reg;
        f_next         = f_reg;
        u_next         = u_reg;
        s_next         = s_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        price_next     = price_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        out_value_next = out_value_reg;
        out_sum_next   = out_sum_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && !result.ready;
        shr   = '0;
        tsum  = '0;
        y     = '0;
        q0    = '0;
        qk    = '0;
        rem   = '0;
        q     = '0;
        rsh   = '0;
        lsh   = '0;
        p     = '0;
        pr    = '0;
        v     = '0;
        sum_w = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // clearing request restarts path and totals
                if (accept && sample.clear_totals)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    price_next = start_reg;
                    step_next  = '0;
                end
            end
            ST_TC:
            begin
                // t = floor(diffusion*z / 2^12) + drift, clamped to +-24
                shr  = prod_reg >>> 12;
                tsum = $signed(shr[37:0]) + 38'(drift_reg);
                if (tsum > EXP_CLAMP)
                    tsum = EXP_CLAMP;
                else if (tsum < -EXP_CLAMP)
                    tsum = -EXP_CLAMP;
                t_next = 35'(tsum);
            end
            ST_YC:
            begin
                // y = t*log2(e); integer and fraction parts
                shr    = prod_reg >>> 29;
                y      = $signed(shr[35:0]);
                n_next = y[35:28];
                f_next = y[27:0];
            end
            ST_UC:
            begin
                u_next = prod_reg[57:28];
                s_next = ONE_Q30;
                k_next = 4'd10;
            end
            ST_H1C:
            begin
                // x = u*s / 2^30; divide by one needs no reciprocal
                x_next = prod_reg[61:30];
                if (k_reg == 4'd1)
                    s_next = ONE_Q30 + prod_reg[61:30];
            end
            ST_H2C:
            begin
                // quotient estimate is low by at most one
                q0  = prod_reg[63:32];
                qk  = 36'(q0) * 36'(k_reg);
                rem = 36'(x_reg) - qk;
                q   = (rem >= 36'(k_reg)) ? q0 + 32'd1 : q0;
                s_next = ONE_Q30 + q;
                k_next = k_reg - 4'd1;
            end
            ST_PC:
            begin
                // scale by 2^(n-30) with saturation
                p   = prod_reg[62:0];
                rsh = 9'sd30 - 9'(n_reg);
                if (rsh >= 9'sd63)
                    price_next = '0;
                else if (rsh >= 9'sd0)
                begin
                    pr = p >> rsh[5:0];
                    price_next = (pr[62:32] != '0) ? 32'hFFFF_FFFF : pr[31:0];
                end
                else
                begin
                    lsh = 6'(-rsh);
                    if (lsh >= 6'd32 || p > (63'h0_FFFF_FFFF >> lsh))
                        price_next = 32'hFFFF_FFFF;
                    else
                    begin
                        pr = p << lsh;
                        price_next = pr[31:0];
                    end
                end
            end
            ST_DONE:
            begin
                if (!finish)
                    step_next = step_inc;
                else if (out_free)
                begin
                    case (mode_reg)
                        MODE_PUT:  v = (strike_reg > price_reg) ? strike_reg - price_reg : '0;
                        MODE_CALL: v = (price_reg > strike_reg) ? price_reg - strike_reg : '0;
                        default:   v = price_reg;
                    endcase
                    sum_w = {1'b0, sum_reg} + 49'(v);
                    sum_next = sum_w[48] ? SUM_MAX : sum_w[47:0];
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + 24'd1;
                    // totals are held with the result so a later clear leaves them intact
                    out_value_next = v;
                    out_sum_next   = sum_next;
                    out_count_next = count_next;
                    out_valid_next = 1'b1;
                    price_next     = start_reg;
                    step_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 32'd6553600;
            strike_reg    <= 32'd6553600;
            drift_reg     <= '0;
            diff_reg      <= '0;
            inc_reg       <= 12'd251;
            mode_reg      <= MODE_PUT;
            price_reg     <= 32'd6553600;
            step_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            price_reg     <= price_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_START_PRICE: start_reg  <= cfg.data;
                    REG_STRIKE:      strike_reg <= cfg.data;
                    REG_DRIFT:       drift_reg  <= $signed(cfg.data);
                    REG_DIFFUSION:   diff_reg   <= cfg.data[30:0];
                    REG_INCREMENTS:  inc_reg    <= cfg.data[11:0];
                    REG_MODE:        mode_reg   <= cfg.data[1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            z_reg <= sample.normal_sample;
        prod_reg      <= prod_next;
        t_reg         <= t_next;
        n_reg         <= n_next;
        f_reg         <= f_next;
        u_reg         <= u_next;
        s_reg         <= s_next;
        x_reg         <= x_next;
        out_value_reg <= out_value_next;
        out_sum_reg   <= out_sum_next;
        out_count_reg <= out_count_next;
    end

    `GPA_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_T)
    `GPA_ASSERT_IMPLY(a_step_below_max, clk, rst_n, state_reg == ST_IDLE, step_reg != 12'hFFF)
    `GPA_ASSERT_IMPLY(a_horner_k, clk, rst_n, state_reg == ST_H1 || state_reg == ST_H2, k_reg != 4'd0 && k_reg <= 4'd10)
    `GPA_ASSERT_IMPLY(a_count_posted, clk, rst_n, result.valid, result.paths_done != 24'd0)

endmodule
`default_nettype wire
